/* hdl/brrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brrt_pkg
// Shared types and codes for the byte range reassembly table.
// ----------------------------------------------------------------------------
package brrt_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SIZE   = 2'd1,
        REQ_FETCH  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_COVERED = 3'd1,
        ST_MIXED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NA      = 3'd4,
        ST_DONE    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FETCH_CHK,
        S_FETCH_EMIT,
        S_EMIT
    } t_state;

    localparam int unsigned CONTIG_MAX = 20'hFFFFF;
    localparam int unsigned MAX_PIECES = 16;

endpackage

/* hdl/brrt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brrt_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/byte_range_reassembly_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_range_reassembly_table
// Sorted range table held in one RAM; a sequencer scans, shifts and answers.
//
//  channel | signals                                         | dir
//  in      | i_valid/o_ready, req_type, byte_offset, count, ov | in
//  out     | o_valid/i_ready, status, index, poff, plen, contig, last | out
//
// One request at a time. An insert or query scans the table one entry per
// cycle (the RAM read port); an insert that opens a gap then moves each later
// entry up by a read (S_SHIFT_RD) and a write (S_SHIFT_WR), then writes the new
// entry. A fetch scans, then emits one piece per cycle while i_ready is high.
// Clear passes through S_EMIT to the result register. Reset empties the table
// at once. The result register holds while i_ready is low.
// ----------------------------------------------------------------------------
module byte_range_reassembly_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int OFFSET_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_req_type,
    input  logic [OFFSET_BITS-1:0] i_byte_offset,
    input  logic [15:0]            i_byte_count,
    input  logic                   i_offset_valid,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_status,
    output logic [3:0]             o_entry_index,
    output logic [15:0]            o_piece_offset,
    output logic [15:0]            o_piece_length,
    output logic [19:0]            o_contiguous_bytes,
    output logic                   o_last
);
    import brrt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int OB = OFFSET_BITS;
    localparam int EW = OB + 16;
    localparam logic [OB-1:0] OMASK = {OB{1'b1}};

    // RAM: {start, length}
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    brrt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic r_tag, n_tag;
    t_req r_req, n_req;
    logic [OB-1:0] r_off, n_off;
    logic [16:0] r_cnt, n_cnt;
    logic r_ov, n_ov;
    logic [CW-1:0] r_i, n_i;          // scan index (entry whose data arrives)
    logic [OB:0] r_pend, n_pend;      // end of previous entry
    logic [20:0] r_tot, n_tot;
    logic r_found, n_found;
    // pending write for insert/shift
    logic [CW-1:0] r_ins, n_ins;
    logic [EW-1:0] r_new, n_new;
    logic [EW-1:0] r_hold, n_hold;
    // fetch
    logic [CW-1:0] r_fi, n_fi;        // first piece index
    logic [4:0] r_np, n_np;
    logic [15:0] r_poff0, n_poff0;
    logic [15:0] r_last_len, n_last_len;
    logic [CW-1:0] r_k, n_k;
    // result register
    logic r_ov_o, n_ov_o;
    logic [2:0] r_st, n_st;
    logic [3:0] r_idx, n_idx;
    logic [15:0] r_po, n_po, r_pl, n_pl;
    logic [19:0] r_cb, n_cb;
    logic r_lst, n_lst;

    logic [OB-1:0] e_s;
    logic [15:0] e_l;
    logic [OB:0] e_end;
    logic [OB:0] room;
    logic [16:0] cclip;
    logic [OB:0] skip, gap;
    logic [16:0] len;

    assign e_s   = ram_rdata[EW-1:16];
    assign e_l   = ram_rdata[15:0];
    assign e_end = {1'b0, e_s} + {{(OB-15){1'b0}}, e_l};

    assign o_ready = (r_state == S_IDLE) && (!r_ov_o || i_ready);
    assign o_valid = r_ov_o;
    assign o_status = r_st;
    assign o_entry_index = r_idx;
    assign o_piece_offset = r_po;
    assign o_piece_length = r_pl;
    assign o_contiguous_bytes = r_cb;
    assign o_last = r_lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tag   <= 1'b0;
            r_ov_o  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_tag   <= n_tag;
            r_ov_o  <= n_ov_o;
        end
        r_req <= n_req; r_off <= n_off; r_cnt <= n_cnt; r_ov <= n_ov;
        r_i <= n_i; r_pend <= n_pend;
        r_tot <= n_tot; r_found <= n_found; r_ins <= n_ins; r_new <= n_new;
        r_hold <= n_hold; r_fi <= n_fi; r_np <= n_np; r_poff0 <= n_poff0;
        r_last_len <= n_last_len; r_k <= n_k;
        r_st <= n_st; r_idx <= n_idx; r_po <= n_po; r_pl <= n_pl;
        r_cb <= n_cb; r_lst <= n_lst;
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_tag = r_tag;
        n_req = r_req; n_off = r_off; n_cnt = r_cnt; n_ov = r_ov;
        n_i = r_i; n_pend = r_pend;
        n_tot = r_tot; n_found = r_found; n_ins = r_ins; n_new = r_new;
        n_hold = r_hold; n_fi = r_fi; n_np = r_np; n_poff0 = r_poff0;
        n_last_len = r_last_len; n_k = r_k;
        n_ov_o = r_ov_o; n_st = r_st; n_idx = r_idx; n_po = r_po; n_pl = r_pl;
        n_cb = r_cb; n_lst = r_lst;
        ram_we = 1'b0; ram_waddr = r_ins[AW-1:0]; ram_wdata = r_new;
        ram_raddr = r_i[AW-1:0];
        room = '0; cclip = '0; skip = '0; gap = '0; len = '0;

        if (r_ov_o && i_ready) begin
            n_ov_o = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (i_valid && o_ready) begin
                    n_req = t_req'(i_req_type);
                    n_off = i_byte_offset;
                    n_cnt = {1'b0, i_byte_count};
                    n_ov  = i_offset_valid;
                    n_i = '0; n_pend = '0; n_tot = '0;
                    n_found = 1'b0; n_np = '0; n_k = '0;
                    n_st = ST_DONE; n_idx = '0; n_po = '0; n_pl = '0; n_cb = '0;
                    n_lst = 1'b1;
                    n_state = S_RD;
                    // last entry read for append paths
                    if (t_req'(i_req_type) == REQ_INSERT && r_count != 0 &&
                        !r_tag) begin
                        n_i = r_count - 1'b1;
                    end
                    if (t_req'(i_req_type) == REQ_CLEAR) begin
                        n_count = '0; n_tag = 1'b0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_RD: begin
                // RAM read of entry r_i issued; data next cycle
                n_state = S_SCAN;
                if (r_req == REQ_INSERT) begin
                    if (r_count != 0 && r_tag && !r_ov) begin
                        n_st = ST_MIXED; n_state = S_EMIT;
                    end else if (r_count == 0) begin
                        room = {1'b0, OMASK} - (r_ov ? {1'b0, r_off} : '0);
                        cclip = (room < {{(OB-16){1'b0}}, r_cnt}) ? room[16:0] : r_cnt;
                        if (cclip == 0) begin
                            n_st = ST_COVERED;
                        end else begin
                            n_tag = r_ov;
                            n_ins = '0;
                            n_new = {(r_ov ? r_off : {OB{1'b0}}), cclip[15:0]};
                            n_count = CW'(1);
                            n_st = ST_STORED; n_idx = '0; n_pl = cclip[15:0];
                            ram_we = 1'b1; ram_waddr = '0;
                            ram_wdata = {(r_ov ? r_off : {OB{1'b0}}), cclip[15:0]};
                        end
                        n_state = S_EMIT;
                    end else if (r_tag) begin
                        room = {1'b0, OMASK} - {1'b0, r_off};
                        cclip = (room < {{(OB-16){1'b0}}, r_cnt}) ? room[16:0] : r_cnt;
                        n_cnt = cclip;
                        if (cclip == 0) begin
                            n_st = ST_COVERED; n_state = S_EMIT;
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = AW'(r_i + 1'b1);
                case (r_req)
                    REQ_INSERT: begin
                        if (!r_tag) begin
                            // append after last entry
                            room = {1'b0, OMASK} - e_end;
                            cclip = (room < {{(OB-16){1'b0}}, r_cnt}) ? room[16:0] : r_cnt;
                            if (cclip == 0) begin
                                n_st = ST_COVERED;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                ram_we = 1'b1; ram_waddr = r_count[AW-1:0];
                                ram_wdata = {e_end[OB-1:0], cclip[15:0]};
                                n_count = r_count + 1'b1;
                                n_st = ST_STORED; n_idx = 4'(r_count);
                                n_pl = cclip[15:0];
                            end
                            n_state = S_EMIT;
                        end else if (r_i == r_count) begin
                            // past the end
                            skip = (r_off >= r_pend) ? '0 : r_pend - {1'b0, r_off};
                            if (skip >= {{(OB-16){1'b0}}, r_cnt}) begin
                                n_st = ST_COVERED; n_idx = 4'(r_count - 1'b1);
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                len = r_cnt - skip[16:0];
                                ram_we = 1'b1; ram_waddr = r_count[AW-1:0];
                                ram_wdata = {OB'({1'b0, r_off} + skip), len[15:0]};
                                n_count = r_count + 1'b1;
                                n_st = ST_STORED; n_idx = 4'(r_count);
                                n_po = skip[15:0]; n_pl = len[15:0];
                            end
                            n_state = S_EMIT;
                        end else if (e_s < r_off) begin
                            n_pend = e_end; n_i = r_i + 1'b1;
                        end else if (e_s == r_off) begin
                            // need next entry start: read it
                            n_hold = ram_rdata; n_ins = r_i;
                            n_state = S_FETCH_CHK;
                        end else begin
                            n_idx = 4'(r_i);
                            skip = (r_off >= r_pend) ? '0 : r_pend - {1'b0, r_off};
                            gap = {1'b0, e_s} - ({1'b0, r_off} + skip);
                            if (r_pend == {1'b0, e_s} ||
                                skip >= {{(OB-16){1'b0}}, r_cnt}) begin
                                n_st = ST_COVERED; n_state = S_EMIT;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                n_st = ST_FULL; n_idx = '0; n_state = S_EMIT;
                            end else begin
                                len = r_cnt - skip[16:0];
                                if (gap < {{(OB-16){1'b0}}, len}) len = gap[16:0];
                                n_new = {OB'({1'b0, r_off} + skip), len[15:0]};
                                n_st = ST_STORED; n_po = skip[15:0];
                                n_pl = len[15:0];
                                n_ins = r_i;
                                n_k = r_count;
                                n_state = S_SHIFT_RD;
                            end
                        end
                    end
                    REQ_SIZE: begin
                        if (!r_found) begin
                            if (r_i == r_count || e_s > r_off) begin
                                n_state = S_EMIT;
                            end else if (e_end > {1'b0, r_off}) begin
                                n_found = 1'b1; n_idx = 4'(r_i);
                                n_tot = 21'(e_end - {1'b0, r_off});
                                n_pend = e_end; n_i = r_i + 1'b1;
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                        end else if (r_i == r_count || {1'b0, e_s} != r_pend) begin
                            n_state = S_EMIT;
                        end else begin
                            n_tot = r_tot + 21'(e_l);
                            if (r_tot[20]) n_tot = r_tot;
                            n_pend = e_end; n_i = r_i + 1'b1;
                        end
                        if (n_state == S_EMIT) begin
                            n_cb = (r_tot > 21'(CONTIG_MAX)) ? 20'(CONTIG_MAX) : r_tot[19:0];
                            if (!r_found) n_cb = '0;
                        end
                    end
                    default: begin // fetch
                        if (!r_found) begin
                            if (r_i == r_count || e_s > r_off) begin
                                n_st = ST_NA; n_state = S_EMIT;
                            end else if (e_end > {1'b0, r_off}) begin
                                n_found = 1'b1; n_fi = r_i;
                                n_poff0 = 16'(r_off - e_s);
                                skip = e_end - {1'b0, r_off};
                                len = (skip < {{(OB-16){1'b0}}, r_cnt}) ? skip[16:0] : r_cnt;
                                n_cnt = r_cnt - len; n_last_len = len[15:0];
                                n_hold = {r_hold[EW-1:16], len[15:0]};
                                n_np = 5'd1; n_pend = e_end; n_i = r_i + 1'b1;
                                if (len == r_cnt) begin
                                    n_state = S_FETCH_EMIT; n_k = r_i;
                                end
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                        end else if (r_i == r_count || {1'b0, e_s} != r_pend ||
                                     r_np == 5'(MAX_PIECES)) begin
                            n_st = ST_NA; n_state = S_EMIT;
                        end else begin
                            len = ({1'b0, e_l} < r_cnt) ? {1'b0, e_l} : r_cnt;
                            n_cnt = r_cnt - len; n_last_len = len[15:0];
                            n_np = r_np + 1'b1; n_pend = e_end; n_i = r_i + 1'b1;
                            if (len == r_cnt) begin
                                n_state = S_FETCH_EMIT; n_k = r_fi;
                            end
                        end
                    end
                endcase
            end
            S_FETCH_CHK: begin
                // insert at matching start; ram_rdata is entry r_i+1 (if any)
                ram_raddr = AW'(r_i + 1'b1);
                len = r_cnt;
                gap = {1'b0, e_s} - {1'b0, r_hold[EW-1:16]};
                if (r_i + 1'b1 < r_count && gap < {{(OB-16){1'b0}}, len}) begin
                    len = gap[16:0];
                end
                n_idx = 4'(r_i);
                if (len <= {1'b0, r_hold[15:0]}) begin
                    n_st = ST_COVERED;
                end else begin
                    ram_we = 1'b1; ram_waddr = r_i[AW-1:0];
                    ram_wdata = {r_hold[EW-1:16], len[15:0]};
                    n_st = ST_STORED; n_pl = len[15:0];
                end
                n_state = S_EMIT;
            end
            S_SHIFT_RD: begin
                // r_k: destination; read k-1
                if (r_k == r_ins) begin
                    ram_we = 1'b1; ram_waddr = r_ins[AW-1:0]; ram_wdata = r_new;
                    n_count = r_count + 1'b1;
                    n_state = S_EMIT;
                end else begin
                    ram_raddr = AW'(r_k - 1'b1);
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we = 1'b1; ram_waddr = r_k[AW-1:0]; ram_wdata = ram_rdata;
                n_k = r_k - 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_FETCH_EMIT: begin
                if (!r_ov_o || i_ready) begin
                    n_ov_o = 1'b1; n_st = ST_DONE; n_idx = 4'(r_k);
                    n_po = (r_k == r_fi) ? r_poff0 : '0;
                    n_cb = '0;
                    if (r_k - r_fi == CW'(r_np - 1'b1)) begin
                        n_pl = r_last_len; n_lst = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_pl = (r_k == r_fi) ? r_hold[15:0] : e_l;
                        n_lst = 1'b0;
                        n_k = r_k + 1'b1;
                    end
                end
                ram_raddr = AW'(n_k);
            end
            S_EMIT: begin
                if (!r_ov_o || i_ready) begin
                    n_ov_o = 1'b1;
                    n_state = S_IDLE;
                    if (r_st != ST_STORED && r_st != ST_DONE) begin
                        n_po = '0; n_pl = '0;
                    end
                    if (r_st == ST_FULL || r_st == ST_MIXED) n_idx = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the byte range reassembly table against a behavioral range table.
// Directed requests cover the insert, query, fetch and clear corner cases;
// random request streams with random idling on both channels follow.
// ----------------------------------------------------------------------------
module tb_top;
    import brrt_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [47:0] OFS_ALL = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  index;
        logic [15:0] poff;
        logic [15:0] plen;
        logic [19:0] contig;
        logic        last;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [47:0] i_byte_offset = '0;
    logic [15:0] i_byte_count = '0;
    logic        i_offset_valid = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_entry_index;
    logic [15:0] o_piece_offset;
    logic [15:0] o_piece_length;
    logic [19:0] o_contiguous_bytes;
    logic        o_last;

    byte_range_reassembly_table u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    logic [47:0] tbl_start [DEPTH];
    logic [16:0] tbl_len [DEPTH];
    int          tbl_count;
    bit          tbl_tagged;

    t_answer answer_q[$];
    int      mismatches;
    int      answers_seen;
    int      transfers_sent;
    bit      stall_enable;

    function automatic logic [48:0] range_end(int i);
        return {1'b0, tbl_start[i]} + tbl_len[i];
    endfunction

    function automatic t_answer mk(t_status st, int idx, logic [63:0] po, logic [63:0] pl,
                                   logic [63:0] ct, bit lst);
        t_answer a;
        a.status = st;
        a.index  = idx[3:0];
        a.poff   = po[15:0];
        a.plen   = pl[15:0];
        a.contig = ct[19:0];
        a.last   = lst;
        return a;
    endfunction

    task automatic predict_insert(logic [47:0] off, logic [15:0] cnt_in, bit ov);
        int          n;
        logic [63:0] s, room, cnt, need, prev_end, skip, ns, len;
        n = tbl_count;
        cnt = cnt_in;
        if (n > 0 && tbl_tagged && !ov) begin
            answer_q.push_back(mk(ST_MIXED, 0, 0, 0, 0, 1));
            return;
        end
        if (n == 0 || !tbl_tagged) begin
            s = (n == 0) ? (ov ? off : 0) : range_end(n - 1);
            room = OFS_ALL - s;
            if (cnt > room) cnt = room;
            if (cnt == 0) begin
                answer_q.push_back(mk(ST_COVERED, 0, 0, 0, 0, 1));
            end else if (n >= DEPTH) begin
                answer_q.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
            end else begin
                if (n == 0) tbl_tagged = ov;
                tbl_start[n] = s[47:0];
                tbl_len[n] = cnt[16:0];
                tbl_count = n + 1;
                answer_q.push_back(mk(ST_STORED, n, 0, cnt, 0, 1));
            end
            return;
        end
        room = OFS_ALL - off;
        if (cnt > room) cnt = room;
        if (cnt == 0) begin
            answer_q.push_back(mk(ST_COVERED, 0, 0, 0, 0, 1));
            return;
        end
        for (int i = 0; i < n; i++) begin
            s = tbl_start[i];
            if (s < off) continue;
            if (s == off) begin
                need = cnt;
                if (i + 1 < n && tbl_start[i + 1] - s < need) need = tbl_start[i + 1] - s;
                if (need <= tbl_len[i]) begin
                    answer_q.push_back(mk(ST_COVERED, i, 0, 0, 0, 1));
                end else begin
                    tbl_len[i] = need[16:0];
                    answer_q.push_back(mk(ST_STORED, i, 0, need, 0, 1));
                end
                return;
            end
            prev_end = (i > 0) ? range_end(i - 1) : 0;
            if (prev_end == s) begin
                answer_q.push_back(mk(ST_COVERED, i, 0, 0, 0, 1));
                return;
            end
            skip = (off >= prev_end) ? 0 : prev_end - off;
            if (skip >= cnt) begin
                answer_q.push_back(mk(ST_COVERED, i, 0, 0, 0, 1));
                return;
            end
            ns = off + skip;
            len = cnt - skip;
            if (len > s - ns) len = s - ns;
            if (n >= DEPTH) begin
                answer_q.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
                return;
            end
            for (int j = n; j > i; j--) begin
                tbl_start[j] = tbl_start[j - 1];
                tbl_len[j] = tbl_len[j - 1];
            end
            tbl_start[i] = ns[47:0];
            tbl_len[i] = len[16:0];
            tbl_count = n + 1;
            answer_q.push_back(mk(ST_STORED, i, skip, len, 0, 1));
            return;
        end
        prev_end = range_end(n - 1);
        skip = (off >= prev_end) ? 0 : prev_end - off;
        if (skip >= cnt) begin
            answer_q.push_back(mk(ST_COVERED, n - 1, 0, 0, 0, 1));
        end else if (n >= DEPTH) begin
            answer_q.push_back(mk(ST_FULL, 0, 0, 0, 0, 1));
        end else begin
            ns = off + skip;
            len = cnt - skip;
            tbl_start[n] = ns[47:0];
            tbl_len[n] = len[16:0];
            tbl_count = n + 1;
            answer_q.push_back(mk(ST_STORED, n, skip, len, 0, 1));
        end
    endtask

    task automatic predict_size(logic [47:0] off);
        logic [63:0] total;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] > off) break;
            if (range_end(i) > off) begin
                total = range_end(i) - off;
                for (int j = i + 1; j < tbl_count && tbl_start[j] == range_end(j - 1); j++)
                    total += tbl_len[j];
                if (total > CONTIG_MAX) total = CONTIG_MAX;
                answer_q.push_back(mk(ST_DONE, i, 0, 0, total, 1));
                return;
            end
        end
        answer_q.push_back(mk(ST_DONE, 0, 0, 0, 0, 1));
    endtask

    task automatic predict_fetch(logic [47:0] off, logic [15:0] size_in);
        t_answer     pieces[$];
        int          i, j;
        logic [63:0] size, take;
        size = size_in;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] > off) break;
            if (range_end(i) > off) break;
        end
        if (i >= tbl_count || tbl_start[i] > off) begin
            answer_q.push_back(mk(ST_NA, 0, 0, 0, 0, 1));
            return;
        end
        take = range_end(i) - off;
        if (take > size) take = size;
        pieces.push_back(mk(ST_DONE, i, off - tbl_start[i], take, 0, 0));
        size -= take;
        j = i;
        while (size > 0) begin
            if (j + 1 >= tbl_count || tbl_start[j + 1] != range_end(j)
                || pieces.size() >= MAX_PIECES) begin
                answer_q.push_back(mk(ST_NA, 0, 0, 0, 0, 1));
                return;
            end
            j++;
            take = tbl_len[j];
            if (take > size) take = size;
            pieces.push_back(mk(ST_DONE, j, 0, take, 0, 0));
            size -= take;
        end
        pieces[pieces.size() - 1].last = 1'b1;
        foreach (pieces[k]) answer_q.push_back(pieces[k]);
    endtask

    task automatic random_gap(bit sender);
        int g;
        if (!stall_enable) return;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (sender && g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_request(t_req rq, logic [47:0] off, logic [15:0] cnt, bit ov);
        random_gap(1);
        i_valid <= 1'b1;
        i_req_type <= rq;
        i_byte_offset <= off;
        i_byte_count <= cnt;
        i_offset_valid <= ov;
        do @(posedge i_clk); while (!o_ready);
        case (rq)
            REQ_INSERT: predict_insert(off, cnt, ov);
            REQ_SIZE:   predict_size(off);
            REQ_FETCH:  predict_fetch(off, cnt);
            default: begin
                tbl_count = 0;
                tbl_tagged = 0;
                answer_q.push_back(mk(ST_DONE, 0, 0, 0, 0, 1));
            end
        endcase
        transfers_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (answer_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    // Sink side: random backpressure and in-order compare.
    initial begin
        t_answer got, exp;
        int g;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{o_status, o_entry_index, o_piece_offset, o_piece_length,
                        o_contiguous_bytes, o_last};
                answers_seen++;
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer %p", got);
                end else begin
                    exp = answer_q.pop_front();
                    if (got !== exp) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp, got);
                    end
                end
            end
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_request(REQ_SIZE, 0, 1, 0);
        send_request(REQ_FETCH, 0, 1, 0);
        send_request(REQ_INSERT, 100, 0, 1);
        send_request(REQ_INSERT, 100, 50, 1);
        send_request(REQ_INSERT, 200, 50, 1);
        send_request(REQ_INSERT, 10, 20, 0);
        send_request(REQ_INSERT, 100, 80, 1);
        send_request(REQ_INSERT, 100, 10, 1);
        send_request(REQ_INSERT, 120, 300, 1);
        send_request(REQ_INSERT, 50, 16'hFFFF, 1);
        send_request(REQ_INSERT, 0, 20, 1);
        send_request(REQ_SIZE, 60, 0, 0);
        send_request(REQ_FETCH, 30, 200, 0);
        send_request(REQ_FETCH, 110, 0, 0);
        send_request(REQ_FETCH, 5, 100, 0);
        send_request(REQ_SIZE, 20000, 0, 1);
        send_request(REQ_CLEAR, OFS_ALL, 16'hFFFF, 1);
        send_request(REQ_INSERT, OFS_ALL - 5, 16'hFFFF, 1);
        send_request(REQ_INSERT, OFS_ALL, 16'hFFFF, 1);
        send_request(REQ_CLEAR, 0, 1, 0);
        for (int i = 0; i < 17; i++) send_request(REQ_INSERT, 48'h5555, 16'hFFFF, 0);
        send_request(REQ_SIZE, 3, 0, 0);
        send_request(REQ_FETCH, 100, 16'hFFFF, 0);
        send_request(REQ_CLEAR, 0, 1, 0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [47:0] base, off;
        int          t;
        stall_enable = 1;
        for (int n = 0; n < 260; n++) begin
            if (n == 130) stall_enable = 0;
            if (n == 160) stall_enable = 1;
            t = $urandom_range(0, 99);
            base = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) : 48'd1000;
            off = base + $urandom_range(0, 600);
            if (t < 3) send_request(REQ_CLEAR, 48'({$urandom, $urandom}), 16'($urandom),
                                    1'($urandom));
            else if (t < 55)
                send_request(REQ_INSERT, off, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                             : 16'($urandom_range(0, 120)), $urandom_range(0, 7) != 0);
            else if (t < 75) send_request(REQ_SIZE, off, 16'($urandom), 1'($urandom));
            else send_request(REQ_FETCH, off, 16'($urandom_range(0, 400)), 1'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        tbl_count = 0;
        tbl_tagged = 0;
        mismatches = 0;
        answers_seen = 0;
        transfers_sent = 0;
        stall_enable = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        $display("covered %0d requests and %0d result transfers with random idling",
                 transfers_sent, answers_seen);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, answer_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
